// File: hw/rtl/signature_trie_matcher_top_defines.svh
// assertion macros shared by the matcher checker
// depends on nothing; included by files that assert
`ifndef SIGNATURE_TRIE_MATCHER_TOP_DEFINES_SVH
`define SIGNATURE_TRIE_MATCHER_TOP_DEFINES_SVH

// property checked only while out of reset
`define STM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");

// property checked on every edge, reset included
`define STM_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// File: hw/rtl/stm_pkg.sv
// types and constants of the signature trie matcher
// used by the interfaces, controller, datapath and top level
package stm_pkg;

  localparam int NODES     = 256;
  localparam int SYMBOLS   = 257;
  localparam int TYPES     = 16;
  localparam int MAX_LEN   = 64;
  localparam int NODE_W    = $clog2(NODES);
  localparam int FREE_W    = $clog2(NODES + 1);
  localparam int ADDR_W    = $clog2(NODES * SYMBOLS);
  localparam int POS_W     = $clog2(MAX_LEN + 1);
  localparam int SYM_W     = 9;
  localparam int TYPE_W    = 4;
  localparam int STATUS_W  = 2;
  localparam int CNT_W     = 9;
  localparam int CNT_MAX   = 511;
  localparam int WILDCARD  = 256;

  typedef enum logic {
    OP_INSERT   = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CLASSIFIED = 2'd0,
    ST_NEW        = 2'd1,
    ST_OVERWRITE  = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  typedef struct packed {
    logic capture;
    logic clr;
    logic rd_lit;
    logic rd_wc;
    logic rd_type;
    logic ins_upd;
    logic set_full;
    logic cls_miss;
    logic cls_hit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic last;
    logic stopped;
    logic can_walk;
    logic child_zero;
    logic clr_done;
    logic out_free;
  } stat_t;

endpackage

// File: hw/rtl/stm_if.sv
// channel interfaces of the matcher: input words and result words
// depends on stm_pkg
interface stm_in_if (input logic clk);
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic                       first;
  logic                       last;
  logic [stm_pkg::SYM_W-1:0]  symbol;
  logic [stm_pkg::TYPE_W-1:0] type_code;

  modport source (output valid, operation, first, last, symbol, type_code, input ready);
  modport sink (input valid, operation, first, last, symbol, type_code, output ready);
endinterface

interface stm_out_if (input logic clk);
  logic                         valid;
  logic                         ready;
  logic [stm_pkg::TYPE_W-1:0]   found_type;
  logic [stm_pkg::STATUS_W-1:0] status;
  logic [stm_pkg::CNT_W-1:0]    signature_count;

  modport source (output valid, found_type, status, signature_count, input ready);
  modport sink (input valid, found_type, status, signature_count, output ready);
endinterface

// File: hw/rtl/stm_ctrl.sv
// controller state machine of the matcher
// depends on stm_pkg; drives commands into stm_dp
module stm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  stm_pkg::stat_t  st,
  output stm_pkg::cmd_t   cmd
);

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_LOOK = 7'b0000100,
    S_CHK  = 7'b0001000,
    S_CHK2 = 7'b0010000,
    S_TYPE = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt, done_st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    done_st   = st.last ? S_OUT : S_IDLE;
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (st.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_LOOK;
        end
      end
      S_LOOK: begin
        if (st.op == stm_pkg::OP_INSERT) begin
          if (st.stopped) begin
            cmd.set_full = st.last;
            state_nxt    = done_st;
          end else begin
            cmd.rd_lit = 1'b1;
            state_nxt  = S_CHK;
          end
        end else if (st.stopped || !st.can_walk) begin
          state_nxt = done_st;
        end else begin
          cmd.rd_lit = 1'b1;
          state_nxt  = S_CHK;
        end
      end
      S_CHK: begin
        if (st.op == stm_pkg::OP_INSERT) begin
          cmd.ins_upd = 1'b1;
          state_nxt   = done_st;
        end else if (st.child_zero) begin
          // literal child missing, try the wildcard child
          cmd.rd_wc = 1'b1;
          state_nxt = S_CHK2;
        end else begin
          cmd.rd_type = 1'b1;
          state_nxt   = S_TYPE;
        end
      end
      S_CHK2: begin
        if (st.child_zero) begin
          cmd.cls_miss = 1'b1;
          state_nxt    = done_st;
        end else begin
          cmd.rd_type = 1'b1;
          state_nxt   = S_TYPE;
        end
      end
      S_TYPE: begin
        cmd.cls_hit = 1'b1;
        state_nxt   = done_st;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

endmodule

// File: hw/rtl/stm_dp.sv
// datapath of the matcher: child and type memories, walk registers, result register
// depends on stm_pkg; steered by stm_ctrl
module stm_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  stm_pkg::cmd_t                cmd,
  output stm_pkg::stat_t               st,
  input  logic                         in_operation,
  input  logic                         in_first,
  input  logic                         in_last,
  input  logic [stm_pkg::SYM_W-1:0]    in_symbol,
  input  logic [stm_pkg::TYPE_W-1:0]   in_type_code,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [stm_pkg::TYPE_W-1:0]   out_found_type,
  output logic [stm_pkg::STATUS_W-1:0] out_status,
  output logic [stm_pkg::CNT_W-1:0]    out_signature_count
);

  localparam int LAST_ADDR = stm_pkg::NODES * stm_pkg::SYMBOLS - 1;

  logic [stm_pkg::NODE_W-1:0] child_mem [stm_pkg::NODES * stm_pkg::SYMBOLS];
  logic [stm_pkg::TYPE_W-1:0] type_mem [stm_pkg::NODES];

  // item registers
  logic                       op_r, last_r;
  logic [stm_pkg::SYM_W-1:0]  sym_r;
  logic [stm_pkg::TYPE_W-1:0] type_r;
  // walk and table state
  logic [stm_pkg::NODE_W-1:0] walk_r, hit_node_r;
  logic [stm_pkg::TYPE_W-1:0] best_r, res_type_r;
  logic [stm_pkg::STATUS_W-1:0] res_status_r;
  logic                       stopped_r, out_valid_r;
  logic [stm_pkg::POS_W-1:0]  pos_r;
  logic [stm_pkg::FREE_W-1:0] free_r;
  logic [stm_pkg::CNT_W-1:0]  count_r;
  logic [stm_pkg::ADDR_W-1:0] clr_addr_r, rd_addr, slot_r;
  logic [stm_pkg::NODE_W-1:0] child_rd_r;
  logic [stm_pkg::TYPE_W-1:0] type_rd_r;
  logic [stm_pkg::TYPE_W-1:0] out_type_r;
  logic [stm_pkg::STATUS_W-1:0] out_status_r;
  logic [stm_pkg::CNT_W-1:0]  out_count_r;

  logic [stm_pkg::SYM_W-1:0]  sym_eff, sym_sel;
  logic [stm_pkg::TYPE_W-1:0] type_eff;
  logic                       full, child_zero;
  logic [stm_pkg::NODE_W-1:0] new_node;

  always_comb begin
    if (in_operation == stm_pkg::OP_CLASSIFY) begin
      sym_eff = {1'b0, in_symbol[7:0]};
    end else if (in_symbol > stm_pkg::SYM_W'(stm_pkg::WILDCARD)) begin
      sym_eff = stm_pkg::SYM_W'(stm_pkg::WILDCARD);
    end else begin
      sym_eff = in_symbol;
    end
    type_eff   = (int'(in_type_code) >= stm_pkg::TYPES) ? '0 : in_type_code;
    sym_sel    = cmd.rd_wc ? stm_pkg::SYM_W'(stm_pkg::WILDCARD) : sym_r;
    // node * 257 + symbol
    rd_addr    = stm_pkg::ADDR_W'(walk_r) * stm_pkg::ADDR_W'(stm_pkg::SYMBOLS)
                 + stm_pkg::ADDR_W'(sym_sel);
    full       = (free_r >= stm_pkg::FREE_W'(stm_pkg::NODES));
    child_zero = (child_rd_r == '0);
    new_node   = free_r[stm_pkg::NODE_W-1:0];
  end

  assign st.op         = op_r;
  assign st.last       = last_r;
  assign st.stopped    = stopped_r;
  assign st.can_walk   = (pos_r < stm_pkg::POS_W'(stm_pkg::MAX_LEN));
  assign st.child_zero = child_zero;
  assign st.clr_done   = (clr_addr_r == stm_pkg::ADDR_W'(LAST_ADDR));
  assign st.out_free   = !out_valid_r || out_ready;

  // child memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      child_mem[clr_addr_r] <= '0;
    end else if (cmd.ins_upd && child_zero && !full) begin
      child_mem[slot_r] <= new_node;
    end
    if (cmd.rd_lit || cmd.rd_wc) begin
      child_rd_r <= child_mem[rd_addr];
      slot_r     <= rd_addr;
    end
  end

  // type memory: every node is written when it is allocated
  always_ff @(posedge clk) begin
    if (cmd.ins_upd) begin
      if (!child_zero) begin
        if (last_r) type_mem[child_rd_r] <= type_r;
      end else if (!full) begin
        type_mem[new_node] <= last_r ? type_r : '0;
      end
    end
    if (cmd.rd_type) begin
      type_rd_r  <= type_mem[child_rd_r];
      hit_node_r <= child_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_operation;
      last_r <= in_last;
      sym_r  <= sym_eff;
      type_r <= type_eff;
    end
    if (cmd.set_full) begin
      res_type_r   <= '0;
      res_status_r <= stm_pkg::ST_FULL;
    end else if (cmd.ins_upd && last_r) begin
      if (!child_zero) begin
        res_type_r   <= type_r;
        res_status_r <= stm_pkg::ST_OVERWRITE;
      end else if (full) begin
        res_type_r   <= '0;
        res_status_r <= stm_pkg::ST_FULL;
      end else begin
        res_type_r   <= type_r;
        res_status_r <= stm_pkg::ST_NEW;
      end
    end
    if (cmd.emit) begin
      out_type_r   <= (op_r == stm_pkg::OP_CLASSIFY) ? best_r : res_type_r;
      out_status_r <= (op_r == stm_pkg::OP_CLASSIFY) ? stm_pkg::ST_CLASSIFIED : res_status_r;
      out_count_r  <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r      <= '0;
      best_r      <= '0;
      stopped_r   <= 1'b0;
      pos_r       <= '0;
      free_r      <= stm_pkg::FREE_W'(1);
      count_r     <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr && !st.clr_done) clr_addr_r <= clr_addr_r + 1'b1;
      if ((cmd.capture && in_first) || cmd.emit) begin
        walk_r    <= '0;
        best_r    <= '0;
        stopped_r <= 1'b0;
        pos_r     <= '0;
      end
      if (cmd.ins_upd) begin
        if (!child_zero) begin
          if (!last_r) walk_r <= child_rd_r;
        end else if (full) begin
          if (!last_r) stopped_r <= 1'b1;
        end else begin
          free_r <= free_r + 1'b1;
          if (!last_r) begin
            walk_r <= new_node;
          end else if (count_r != stm_pkg::CNT_W'(stm_pkg::CNT_MAX)) begin
            count_r <= count_r + 1'b1;
          end
        end
      end
      if (cmd.cls_miss) begin
        stopped_r <= 1'b1;
        pos_r     <= pos_r + 1'b1;
      end
      if (cmd.cls_hit) begin
        walk_r <= hit_node_r;
        if (type_rd_r != '0) best_r <= type_rd_r;
        pos_r <= pos_r + 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_found_type      = out_type_r;
  assign out_status          = out_status_r;
  assign out_signature_count = out_count_r;

endmodule

// File: hw/rtl/signature_trie_matcher_top.sv
// a word is captured in S_IDLE; an insert word then passes S_LOOK and S_CHK, a classify word
// S_LOOK, S_CHK, S_CHK2 if the literal child is missing, and S_TYPE, both only S_LOOK once the
// walk has stopped; on a last word S_OUT loads the result register once it is free; one word at
// a time, set by the registered child-table read whose data is the next address; reset:
// synchronous; afterwards a clearing pass zeroes the child table with in_ch.ready low
module signature_trie_matcher_top (
  input logic         clk,
  input logic         rst_n,
  stm_in_if.sink      in_ch,
  stm_out_if.source   out_ch
);

  stm_pkg::cmd_t  cmd;
  stm_pkg::stat_t st;

  stm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  stm_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .in_operation        (in_ch.operation),
    .in_first            (in_ch.first),
    .in_last             (in_ch.last),
    .in_symbol           (in_ch.symbol),
    .in_type_code        (in_ch.type_code),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_found_type      (out_ch.found_type),
    .out_status          (out_ch.status),
    .out_signature_count (out_ch.signature_count)
  );

endmodule

// File: hw/rtl/stm_checker.sv
// port-level checks of the matcher and their bind to the top level
// depends on stm_pkg and signature_trie_matcher_top_defines.svh
`include "signature_trie_matcher_top_defines.svh"

module stm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [stm_pkg::TYPE_W-1:0]   out_found_type,
  input logic [stm_pkg::STATUS_W-1:0] out_status
);

  `STM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `STM_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_status))
  // a full table never reports a type
  `STM_ASSERT(a_full_type, clk, rst_n, out_valid && out_status == stm_pkg::ST_FULL |-> out_found_type == '0)
  // clearing pass follows reset
  `STM_ASSERT_ALL(a_clear_after_reset, clk, !rst_n |=> !in_ready)

endmodule

bind signature_trie_matcher_top stm_checker u_stm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_found_type (out_ch.found_type),
  .out_status     (out_ch.status)
);

// File: dv/tb_stm_if.sv
// testbench copy point for the matcher channel interfaces
// the interfaces themselves live in the rtl file stm_if.sv; this file holds tb-side types
// depends on stm_pkg
`timescale 1ns / 100ps
package tb_stm_pkg;
  import stm_pkg::*;

  typedef struct packed {
    logic [TYPE_W-1:0]   found_type;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    signature_count;
  } result_t;
endpackage

// File: dv/tb_top.sv
// testbench of signature_trie_matcher_top: directed and random insert/classify words
// predicts each result from an in-testbench trie model; depends on stm_pkg, stm_if, tb_stm_pkg
`timescale 1ns / 100ps
module tb_top;
  import stm_pkg::*;
  import tb_stm_pkg::*;

  localparam int LIMIT = 4_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  stm_in_if  in_ch (clk);
  stm_out_if out_ch (clk);

  signature_trie_matcher_top dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  initial begin
    forever #10 clk = ~clk;
  end

  // trie mirror
  logic [NODE_W-1:0] trie_child [NODES][SYMBOLS];
  logic [TYPE_W-1:0] trie_type [NODES];
  int unsigned free_node, sig_total, cur_node, best_type, pos;
  bit stopped;
  result_t pending_results [$];

  int errors = 0;
  int n_checked = 0;
  int n_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;

  function automatic void trie_clear();
    foreach (trie_child[n, s]) trie_child[n][s] = '0;
    foreach (trie_type[n]) trie_type[n] = '0;
    free_node = 1;
    sig_total = 0;
    cur_node = 0; best_type = 0; stopped = 0; pos = 0;
  endfunction

  function automatic void push_result(int unsigned t, status_t st);
    result_t r;
    r.found_type = t[TYPE_W-1:0];
    r.status = st;
    r.signature_count = sig_total[CNT_W-1:0];
    pending_results.push_back(r);
    cur_node = 0; best_type = 0; stopped = 0; pos = 0;
  endfunction

  function automatic void trie_predict(op_t op, bit first, bit last, int unsigned sym,
                                       int unsigned tc);
    int unsigned c;
    if (first) begin
      cur_node = 0; best_type = 0; stopped = 0; pos = 0;
    end
    if (op == OP_INSERT) begin
      if (sym > WILDCARD) sym = WILDCARD;
      if (tc >= TYPES) tc = 0;
      if (!last) begin
        if (!stopped) begin
          c = trie_child[cur_node][sym];
          if (c == 0) begin
            if (free_node >= NODES) stopped = 1;
            else begin
              c = free_node++;
              trie_type[c] = '0;
              trie_child[cur_node][sym] = c[NODE_W-1:0];
            end
          end
          if (c != 0) cur_node = c;
        end
        return;
      end
      if (stopped) begin
        push_result(0, ST_FULL);
        return;
      end
      c = trie_child[cur_node][sym];
      if (c != 0) begin
        trie_type[c] = tc[TYPE_W-1:0];
        push_result(tc, ST_OVERWRITE);
        return;
      end
      if (free_node >= NODES) begin
        push_result(0, ST_FULL);
        return;
      end
      c = free_node++;
      trie_type[c] = tc[TYPE_W-1:0];
      trie_child[cur_node][sym] = c[NODE_W-1:0];
      if (sig_total < CNT_MAX) sig_total++;
      push_result(tc, ST_NEW);
    end else begin
      sym &= 8'hff;
      if (!stopped && pos < MAX_LEN) begin
        c = trie_child[cur_node][sym];
        if (c == 0) c = trie_child[cur_node][WILDCARD];
        if (c == 0) stopped = 1;
        else begin
          cur_node = c;
          if (trie_type[c] != 0) best_type = trie_type[c];
        end
        pos++;
      end
      if (last) push_result(best_type, ST_CLASSIFIED);
    end
  endfunction

  // one word, driven at the falling edge, accepted at a rising edge
  // valid stays up after acceptance until the next falling edge
  task automatic send_word(op_t op, bit first, bit last, int unsigned sym, int unsigned tc);
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.first <= first;
    in_ch.last <= last;
    in_ch.symbol <= sym[SYM_W-1:0];
    in_ch.type_code <= tc[TYPE_W-1:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    trie_predict(op, first, last, sym, tc);
    n_sent++;
  endtask

  // sends a signature; wildcard_pct chooses wildcard symbols
  task automatic send_signature(int len, int unsigned tc, int wildcard_pct);
    for (int i = 0; i < len; i++)
      send_word(OP_INSERT, i == 0, i == len - 1,
                ($urandom_range(99) < wildcard_pct) ? WILDCARD : $urandom_range(7), tc);
  endtask

  task automatic send_data(int len);
    for (int i = 0; i < len; i++)
      send_word(OP_CLASSIFY, i == 0, i == len - 1, $urandom_range(7), 0);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no prediction waiting");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        n_checked++;
        if (out_ch.found_type !== exp_r.found_type) begin
          $error("found_type: expected %0d actual %0d", exp_r.found_type, out_ch.found_type);
          errors++;
        end
        if (out_ch.status !== exp_r.status) begin
          $error("status: expected %0d actual %0d", exp_r.status, out_ch.status);
          errors++;
        end
        if (out_ch.signature_count !== exp_r.signature_count) begin
          $error("signature_count: expected %0d actual %0d", exp_r.signature_count,
                 out_ch.signature_count);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    // field extremes, wildcard, symbol above 256, type codes 0 and 15
    send_word(OP_INSERT, 1, 1, 0, 15);
    send_word(OP_INSERT, 1, 0, 255, 0);
    send_word(OP_INSERT, 0, 1, 511, 9);
    send_word(OP_INSERT, 1, 1, 0, 4);          // overwrite
    send_word(OP_INSERT, 1, 1, 300, 0);        // zero type, wildcard
    send_word(OP_CLASSIFY, 1, 0, 255, 0);
    send_word(OP_CLASSIFY, 0, 1, 0, 15);
    send_word(OP_CLASSIFY, 1, 1, 511, 0);      // upper bits dropped
    send_word(OP_CLASSIFY, 0, 1, 1, 0);        // no first after block end
    send_word(OP_CLASSIFY, 1, 0, 0, 0);        // mixed ops in one block
    send_word(OP_INSERT, 0, 1, 170, 6);
    send_word(OP_CLASSIFY, 1, 0, 42, 0);
    send_word(OP_CLASSIFY, 1, 1, 0, 0);        // restart mid block
    drain();
    // long data: more than MAX_LEN bytes down a wildcard chain
    send_signature(3, 2, 100);
    send_data(MAX_LEN + 8);
    drain();
  endtask

  task automatic test_random(int n_words);
    int start;
    int r;
    start = n_sent;
    while (n_sent - start < n_words) begin
      r = $urandom_range(99);
      if (r < 30) send_signature($urandom_range(1, 4), $urandom_range(15), 20);
      else if (r < 80) send_data($urandom_range(1, 6));
      else send_word(op_t'($urandom_range(1)), $urandom_range(1), $urandom_range(1),
                     $urandom_range(511), $urandom_range(15));
    end
    drain();
  endtask

  task automatic test_table_full();
    // fill the node table, then hit the full status on both paths
    while (free_node < NODES) send_signature($urandom_range(2, 5), $urandom_range(1, 15), 0);
    send_word(OP_INSERT, 1, 0, 200, 0);
    send_word(OP_INSERT, 0, 1, 201, 3);
    send_word(OP_INSERT, 1, 1, 202, 3);
    send_data(4);
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_INSERT;
    in_ch.first = 1'b0;
    in_ch.last = 1'b0;
    in_ch.symbol = '0;
    in_ch.type_code = '0;
    out_ch.ready = 1'b1;
    trie_clear();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(240);
    send_idle_pct = 53;
    test_random(240);
    send_idle_pct = 0; recv_stall_pct = 53;
    test_random(240);
    send_idle_pct = 36; recv_stall_pct = 36;
    test_random(240);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_table_full();
    $display("covered %0d input words and %0d checked results, incl. table full", n_sent,
             n_checked);
    if (errors == 0 && pending_results.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/stm_pkg.sv
hw/rtl/stm_if.sv
hw/rtl/stm_ctrl.sv
hw/rtl/stm_dp.sv
hw/rtl/signature_trie_matcher_top.sv
hw/rtl/stm_checker.sv
dv/tb_stm_if.sv
dv/tb_top.sv
